// ===== rtl/pdll_pkg.sv =====
// Shared types and constants for the pooled doubly linked list core.
// Holds operation and status codes, field widths and the control state encoding.
// No dependencies.
`default_nettype none

package pdll_pkg;

    // Fixed widths of the item fields.
    localparam int NODE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int CAP_W   = 9;
    localparam int VALUE_W = 64;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_DEPTH       = 256;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Operation codes.
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Status codes.
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

    // Control states, one-hot.
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC1 = 4'b0100,
        ST_EXEC2 = 4'b1000
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/pooled_doubly_linked_list_core.sv =====
// Pooled doubly linked list core: link, membership and payload memories with control.
// Depends on pdll_pkg for codes, widths and the state encoding.
`default_nettype none

// Usage
// A command item is accepted at a rising edge where start is high and busy is low.
// op selects append at tail, insert between left_node and right_node, remove node,
// or read node. Each item gives exactly one result item: done is high for one cycle
// with the result fields, and the receiver cannot stall it.
// The state lives in synchronous memories with registered reads. The accept edge
// reads the target node's links; append and insert then write the left side and the
// node's back link in EXEC1, then the node's forward link and right side in EXEC2.
// Remove bridges the predecessor and successor in EXEC1 and frees the node in EXEC2.
// Read, a rejected append or insert and a remove of a node that is not in the list
// finish in EXEC1. done follows the last update edge and a new item may be accepted in
// the same cycle that done is shown. Reset, and every write of the capacity register,
// empties the list and runs a clearing pass that rebuilds the free chain over all DEPTH
// entries, one entry per cycle, with busy held high throughout.
module pooled_doubly_linked_list_core
    import pdll_pkg::*;
#(
    parameter int DEPTH       = DEFAULT_DEPTH,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // Command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          op,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [NODE_W-1:0]   node,
    input  wire logic [NODE_W-1:0]   left_node,
    input  wire logic                left_none,
    input  wire logic [NODE_W-1:0]   right_node,
    input  wire logic                right_none,
    // Result channel
    output logic                     done,
    output logic                     status,
    output logic [NODE_W-1:0]        result_node,
    output logic [VALUE_W-1:0]       node_value,
    output logic [NODE_W-1:0]        next_node,
    output logic                     next_none,
    output logic [NODE_W-1:0]        prev_node,
    output logic                     prev_none,
    output logic [NODE_W-1:0]        head_node,
    output logic                     head_none,
    output logic [LEN_W-1:0]         list_length,
    output logic                     full_res,
    // Capacity register
    input  wire logic                capacity_we,
    input  wire logic [CAP_W-1:0]    capacity_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = IW + 1;
    localparam int CW = (LW > CAP_W) ? LW : CAP_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    // A link is an index with a none flag on top.
    typedef logic [LW-1:0] link_t;
    localparam link_t NIL = {1'b1, {IW{1'b0}}};

    // Convert a port index to a link; indices past the pool read as none.
    function automatic link_t node_to_link(input logic [NODE_W-1:0] idx, input logic none);
        logic absent;
        absent = (32'(idx) >= DEPTH);
        return (none || absent) ? NIL : {1'b0, IW'(idx)};
    endfunction

    // Memories
    link_t                  next_mem [DEPTH];
    link_t                  prev_mem [DEPTH];
    logic                   member_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] pay_mem [DEPTH];

    // Control registers
    state_t           state_reg, state_next;
    link_t            head_reg, head_next;
    link_t            tail_reg, tail_next;
    link_t            free_reg, free_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic [IW-1:0]    clr_reg, clr_next;
    logic             done_reg, done_next;

    // Latched item
    op_t                    op_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [IW-1:0]          tgt_reg;
    logic [NODE_W-1:0]      node_raw_reg;
    logic                   absent_reg;
    logic                   reject_reg;
    link_t                  left_reg;
    link_t                  right_reg;

    // Registered read data
    link_t                  rd_next_reg;
    link_t                  rd_prev_reg;
    logic                   rd_member_reg;
    logic [VALUE_WIDTH-1:0] rd_pay_reg;

    // Result registers
    logic               status_reg, status_next;
    logic [NODE_W-1:0]  result_node_reg, result_node_next;
    logic [VALUE_W-1:0] node_value_reg, node_value_next;
    logic [NODE_W-1:0]  next_node_reg, next_node_next;
    logic               next_none_reg, next_none_next;
    logic [NODE_W-1:0]  prev_node_reg, prev_node_next;
    logic               prev_none_reg, prev_none_next;
    logic [NODE_W-1:0]  head_node_reg, head_node_next;
    logic               head_none_reg, head_none_next;
    logic [LEN_W-1:0]   list_length_reg, list_length_next;
    logic               full_res_reg, full_res_next;

    // Accept-side decode
    logic          accept;
    op_t           op_in;
    link_t         node_lk;
    logic          is_alloc_in;
    logic [IW-1:0] tgt_in;
    link_t         left_in;
    link_t         right_in;

    // Memory write ports
    logic                   next_we, prev_we, member_we, pay_we;
    logic [IW-1:0]          next_waddr, prev_waddr, member_waddr;
    link_t                  next_wdata, prev_wdata;
    logic                   member_wdata;
    logic                   finish;
    link_t                  tgt_link;
    logic                   clr_has_next;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    // Decode the incoming item; the target index also addresses the memory read.
    always_comb
    begin
        op_in       = op_t'(op);
        node_lk     = node_to_link(node, 1'b0);
        is_alloc_in = (op_in == OP_APPEND) || (op_in == OP_INSERT);
        tgt_in      = is_alloc_in ? free_reg[IW-1:0] : node_lk[IW-1:0];
        left_in     = (op_in == OP_APPEND) ? tail_reg : node_to_link(left_node, left_none);
        right_in    = (op_in == OP_APPEND) ? NIL : node_to_link(right_node, right_none);
    end

    // Latch the item at accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op_in;
            value_reg    <= value[VALUE_WIDTH-1:0];
            tgt_reg      <= tgt_in;
            node_raw_reg <= node;
            absent_reg   <= node_lk[IW];
            reject_reg   <= free_reg[IW];
            left_reg     <= left_in;
            right_reg    <= right_in;
        end
    end

    // Link memories: one write port each, read at accept.
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_waddr] <= next_wdata;
        if (accept)
            rd_next_reg <= next_mem[tgt_in];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_waddr] <= prev_wdata;
        if (accept)
            rd_prev_reg <= prev_mem[tgt_in];
    end

    always_ff @(posedge clk)
    begin
        if (member_we)
            member_mem[member_waddr] <= member_wdata;
        if (accept)
            rd_member_reg <= member_mem[tgt_in];
    end

    // Payload memory, written only by an allocation.
    always_ff @(posedge clk)
    begin
        if (pay_we)
            pay_mem[tgt_reg] <= value_reg;
        if (accept)
            rd_pay_reg <= pay_mem[tgt_in];
    end

    // Sequencer: clearing pass, then EXEC1 per item and EXEC2 for an item that updates the list.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        cap_next     = cap_reg;
        clr_next     = clr_reg;
        next_we      = 1'b0;
        next_waddr   = tgt_reg;
        next_wdata   = NIL;
        prev_we      = 1'b0;
        prev_waddr   = tgt_reg;
        prev_wdata   = NIL;
        member_we    = 1'b0;
        member_waddr = tgt_reg;
        member_wdata = 1'b0;
        pay_we       = 1'b0;
        finish       = 1'b0;
        tgt_link     = {1'b0, tgt_reg};
        clr_has_next = (clr_reg != LAST_IDX) &&
                       ((CW'({1'b0, clr_reg}) + CW'(1)) < CW'(cap_reg));

        status_next      = STATUS_DONE;
        result_node_next = '0;
        node_value_next  = '0;
        next_node_next   = '0;
        next_none_next   = 1'b0;
        prev_node_next   = '0;
        prev_none_next   = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Rebuild one entry of the free chain per cycle.
                next_we      = 1'b1;
                next_waddr   = clr_reg;
                next_wdata   = clr_has_next ? {1'b0, IW'(clr_reg + 1'b1)} : NIL;
                prev_we      = 1'b1;
                prev_waddr   = clr_reg;
                prev_wdata   = NIL;
                member_we    = 1'b1;
                member_waddr = clr_reg;
                member_wdata = 1'b0;
                clr_next     = IW'(clr_reg + 1'b1);
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (start)
                    state_next = ST_EXEC1;
            end

            ST_EXEC1:
            begin
                case (op_reg) inside
                    OP_APPEND, OP_INSERT:
                    begin
                        if (reject_reg)
                        begin
                            status_next = STATUS_NO_FREE;
                            finish      = 1'b1;
                        end
                        else
                        begin
                            // Pop the free head, link the left side and store the payload.
                            free_next    = rd_next_reg;
                            count_next   = LEN_W'(count_reg + 1'b1);
                            next_we      = !left_reg[IW];
                            next_waddr   = left_reg[IW-1:0];
                            next_wdata   = tgt_link;
                            prev_we      = 1'b1;
                            prev_waddr   = tgt_reg;
                            prev_wdata   = left_reg;
                            member_we    = 1'b1;
                            member_waddr = tgt_reg;
                            member_wdata = 1'b1;
                            pay_we       = 1'b1;
                            if (left_reg[IW])
                                head_next = tgt_link;
                            if (right_reg[IW])
                                tail_next = tgt_link;
                            state_next = ST_EXEC2;
                        end
                    end

                    OP_REMOVE:
                    begin
                        result_node_next = node_raw_reg;
                        if (absent_reg || !rd_member_reg)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            // Bridge the neighbors around the removed node.
                            next_we    = !rd_prev_reg[IW];
                            next_waddr = rd_prev_reg[IW-1:0];
                            next_wdata = rd_next_reg;
                            prev_we    = !rd_next_reg[IW];
                            prev_waddr = rd_next_reg[IW-1:0];
                            prev_wdata = rd_prev_reg;
                            if (head_reg == tgt_link)
                                head_next = rd_next_reg;
                            if (tail_reg == tgt_link)
                                tail_next = rd_prev_reg;
                            count_next = LEN_W'(count_reg - 1'b1);
                            state_next = ST_EXEC2;
                        end
                    end

                    default:
                    begin
                        // Read: report the stored payload and raw links.
                        result_node_next = node_raw_reg;
                        finish           = 1'b1;
                        if (absent_reg)
                        begin
                            next_none_next = 1'b1;
                            prev_none_next = 1'b1;
                        end
                        else
                        begin
                            node_value_next = VALUE_W'(rd_pay_reg);
                            next_none_next  = rd_next_reg[IW];
                            next_node_next  = rd_next_reg[IW] ? '0
                                              : NODE_W'(rd_next_reg[IW-1:0]);
                            prev_none_next  = rd_prev_reg[IW];
                            prev_node_next  = rd_prev_reg[IW] ? '0
                                              : NODE_W'(rd_prev_reg[IW-1:0]);
                        end
                    end
                endcase
                if (finish)
                    state_next = ST_IDLE;
            end

            ST_EXEC2:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
                case (op_reg) inside
                    OP_APPEND, OP_INSERT:
                    begin
                        // Link the new node forward and the right side back.
                        result_node_next = NODE_W'(tgt_reg);
                        next_we          = 1'b1;
                        next_waddr       = tgt_reg;
                        next_wdata       = right_reg;
                        prev_we          = !right_reg[IW];
                        prev_waddr       = right_reg[IW-1:0];
                        prev_wdata       = tgt_link;
                    end

                    default:
                    begin
                        // Push the removed node on the free list.
                        result_node_next = node_raw_reg;
                        next_we          = 1'b1;
                        next_waddr       = tgt_reg;
                        next_wdata       = free_reg;
                        prev_we          = 1'b1;
                        prev_waddr       = tgt_reg;
                        prev_wdata       = NIL;
                        member_we        = 1'b1;
                        member_waddr     = tgt_reg;
                        member_wdata     = 1'b0;
                        free_next        = tgt_link;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        // A capacity write empties the list and restarts the clearing pass.
        if (capacity_we)
        begin
            cap_next   = capacity_data;
            head_next  = NIL;
            tail_next  = NIL;
            free_next  = (capacity_data != '0) ? {1'b0, {IW{1'b0}}} : NIL;
            count_next = '0;
            clr_next   = '0;
            state_next = ST_CLEAR;
        end

        // List summary after the operation.
        head_none_next   = head_next[IW];
        head_node_next   = head_next[IW] ? '0 : NODE_W'(head_next[IW-1:0]);
        list_length_next = count_next;
        full_res_next    = free_next[IW] && (cap_reg != '0);
        done_next        = finish;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            head_reg  <= NIL;
            tail_reg  <= NIL;
            free_reg  <= {1'b0, {IW{1'b0}}};
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    // Result registers, loaded when an item finishes.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            status_reg      <= status_next;
            result_node_reg <= result_node_next;
            node_value_reg  <= node_value_next;
            next_node_reg   <= next_node_next;
            next_none_reg   <= next_none_next;
            prev_node_reg   <= prev_node_next;
            prev_none_reg   <= prev_none_next;
            head_node_reg   <= head_node_next;
            head_none_reg   <= head_none_next;
            list_length_reg <= list_length_next;
            full_res_reg    <= full_res_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign result_node = result_node_reg;
    assign node_value  = node_value_reg;
    assign next_node   = next_node_reg;
    assign next_none   = next_none_reg;
    assign prev_node   = prev_node_reg;
    assign prev_none   = prev_none_reg;
    assign head_node   = head_node_reg;
    assign head_none   = head_none_reg;
    assign list_length = list_length_reg;
    assign full_res    = full_res_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for pooled_doubly_linked_list_core.
// Runs a directed table of command items and capacity writes, then random phases under several capacities.
// A built-in list model predicts each result. Depends on pdll_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdll_pkg::*;

    localparam int         POOL         = DEFAULT_DEPTH;
    localparam logic [8:0] NO_LINK      = 9'h100;
    localparam int         RAND_ITEMS   = 750;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         CYCLE_LIMIT  = 200000;

    // One command item as it is driven onto the ports.
    typedef struct {
        op_t               op;
        logic [VALUE_W-1:0] value;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] left_node;
        logic              left_none;
        logic [NODE_W-1:0] right_node;
        logic              right_none;
    } cmd_t;

    // One result item as it appears on the result ports.
    typedef struct {
        logic               status;
        logic [NODE_W-1:0]  result_node;
        logic [VALUE_W-1:0] node_value;
        logic [NODE_W-1:0]  next_node;
        logic               next_none;
        logic [NODE_W-1:0]  prev_node;
        logic               prev_none;
        logic [NODE_W-1:0]  head_node;
        logic               head_none;
        logic [LEN_W-1:0]   list_length;
        logic               full_res;
    } res_t;

    typedef enum bit {ROW_CMD, ROW_CFG} row_kind_t;

    // Directed row: a command or a capacity write, with optional hand-written results.
    typedef struct {
        row_kind_t         kind;
        op_t               op;
        logic [63:0]       value;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] left_node;
        logic              left_none;
        logic [NODE_W-1:0] right_node;
        logic              right_none;
        logic [CAP_W-1:0]  cap;
        bit                typed;
        logic              t_status;
        logic [NODE_W-1:0] t_node;
        logic [LEN_W-1:0]  t_len;
        logic              t_full;
    } row_t;

    // kind, op, value, node, left, left_none, right, right_none, cap,
    // typed, status, result_node, length, full
    row_t dir_tab [29] = '{
        '{ROW_CMD, OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0, 1, 0},
        '{ROW_CMD, OP_APPEND, 64'h0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 1, 2, 0},
        '{ROW_CMD, OP_INSERT, 64'h8000_0000_0000_0001, 0, 0, 1, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_INSERT, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 1, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 0, 1, 0, 0, 1, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_READ, 64'h0, 3, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_READ, 64'h0, 2, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_READ, 64'h0, 4, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 3, 0, 0, 0, 0, 0, 1, STATUS_DONE, 3, 4, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 3, 0, 0, 0, 0, 0, 1, STATUS_DONE, 3, 4, 0},
        '{ROW_CMD, OP_READ, 64'h0, 3, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 2, 0, 0, 0, 0, 0, 1, STATUS_DONE, 2, 3, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 4, 0, 0, 0, 0, 0, 1, STATUS_DONE, 4, 2, 0},
        '{ROW_CMD, OP_APPEND, 64'hA5A5_A5A5_A5A5_A5A5, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 4, 3, 0},
        '{ROW_CMD, OP_INSERT, 64'h0000_0000_FFFF_FFFF, 0, 255, 1, 255, 1, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 255, 0, 0, 0, 0, 0, 1, STATUS_DONE, 255, 4, 0},
        '{ROW_CFG, OP_APPEND, 64'h0, 0, 0, 0, 0, 0, 2, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_APPEND, 64'h1, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0, 1, 0},
        '{ROW_CMD, OP_APPEND, 64'h2, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 1, 2, 1},
        '{ROW_CMD, OP_APPEND, 64'h7, 0, 0, 0, 0, 0, 0, 1, STATUS_NO_FREE, 0, 2, 1},
        '{ROW_CMD, OP_INSERT, 64'h8, 0, 0, 1, 0, 1, 0, 1, STATUS_NO_FREE, 0, 2, 1},
        '{ROW_CMD, OP_REMOVE, 64'h0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0, 1, 0},
        '{ROW_CFG, OP_APPEND, 64'h0, 0, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_APPEND, 64'h9, 0, 0, 0, 0, 0, 0, 1, STATUS_NO_FREE, 0, 0, 0},
        '{ROW_CMD, OP_READ, 64'h0, 0, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_REMOVE, 64'h0, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0, 0, 0},
        '{ROW_CFG, OP_APPEND, 64'h0, 0, 0, 0, 0, 0, 511, 0, STATUS_DONE, 0, 0, 0},
        '{ROW_CMD, OP_APPEND, 64'h3, 0, 0, 0, 0, 0, 0, 1, STATUS_DONE, 0, 1, 0},
        '{ROW_CMD, OP_READ, 64'h0, 0, 0, 0, 0, 0, 0, 0, STATUS_DONE, 0, 0, 0}
    };

    // Ports of the core.
    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  left_node;
    logic               left_none;
    logic [NODE_W-1:0]  right_node;
    logic               right_none;
    logic               done;
    logic               status;
    logic [NODE_W-1:0]  result_node;
    logic [VALUE_W-1:0] node_value;
    logic [NODE_W-1:0]  next_node;
    logic               next_none;
    logic [NODE_W-1:0]  prev_node;
    logic               prev_none;
    logic [NODE_W-1:0]  head_node;
    logic               head_none;
    logic [LEN_W-1:0]   list_length;
    logic               full_res;
    logic               capacity_we;
    logic [CAP_W-1:0]   capacity_data;

    // Shadow copy of the list state.
    logic [8:0]         nxt_tbl [POOL];
    logic [8:0]         prv_tbl [POOL];
    logic [VALUE_W-1:0] payload_mem [POOL];
    logic [POOL-1:0]    in_list;
    logic [POOL-1:0]    ever_written = '0;
    logic [8:0]         head_idx;
    logic [8:0]         tail_idx;
    logic [8:0]         free_idx;
    logic [LEN_W-1:0]   node_count;
    int                 cap_used;

    res_t pending_results [$];
    int   fail_cnt = 0;
    int   cyc_cnt  = 0;

    pooled_doubly_linked_list_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .value         (value),
        .node          (node),
        .left_node     (left_node),
        .left_none     (left_none),
        .right_node    (right_node),
        .right_none    (right_none),
        .done          (done),
        .status        (status),
        .result_node   (result_node),
        .node_value    (node_value),
        .next_node     (next_node),
        .next_none     (next_none),
        .prev_node     (prev_node),
        .prev_none     (prev_none),
        .head_node     (head_node),
        .head_none     (head_none),
        .list_length   (list_length),
        .full_res      (full_res),
        .capacity_we   (capacity_we),
        .capacity_data (capacity_data)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Empty the list and chain the used part of the pool as the free list.
    task automatic rebuild_pool(input logic [CAP_W-1:0] cap);
        int i;
        cap_used = (cap > POOL) ? POOL : int'(cap);
        for (i = 0; i < POOL; i++)
        begin
            nxt_tbl[i] = (i + 1 < cap_used) ? 9'(i + 1) : NO_LINK;
            prv_tbl[i] = NO_LINK;
        end
        in_list    = '0;
        head_idx   = NO_LINK;
        tail_idx   = NO_LINK;
        free_idx   = (cap_used != 0) ? 9'd0 : NO_LINK;
        node_count = '0;
    endtask

    // Apply one command to the shadow list and work out its result item.
    task automatic apply_list_op(input cmd_t c, output res_t r);
        logic [8:0] lft;
        logic [8:0] rgt;
        logic [8:0] n;
        logic [8:0] p;
        logic [8:0] q;
        r = '{default: '0};
        if (c.op == OP_APPEND || c.op == OP_INSERT)
        begin
            if (c.op == OP_APPEND)
            begin
                lft = tail_idx;
                rgt = NO_LINK;
            end
            else
            begin
                lft = c.left_none ? NO_LINK : {1'b0, c.left_node};
                rgt = c.right_none ? NO_LINK : {1'b0, c.right_node};
            end
            if (free_idx == NO_LINK)
            begin
                r.status = STATUS_NO_FREE;
            end
            else
            begin
                n = free_idx;
                free_idx = nxt_tbl[n[7:0]];
                payload_mem[n[7:0]]  = c.value;
                in_list[n[7:0]]      = 1'b1;
                ever_written[n[7:0]] = 1'b1;
                node_count++;
                // Links are written as given, left side first.
                if (lft != NO_LINK)
                    nxt_tbl[lft[7:0]] = n;
                prv_tbl[n[7:0]] = lft;
                nxt_tbl[n[7:0]] = rgt;
                if (rgt != NO_LINK)
                    prv_tbl[rgt[7:0]] = n;
                if (lft == NO_LINK)
                    head_idx = n;
                if (rgt == NO_LINK)
                    tail_idx = n;
                r.status      = STATUS_DONE;
                r.result_node = n[7:0];
            end
        end
        else if (c.op == OP_REMOVE)
        begin
            r.result_node = c.node;
            // A node that is not in the list is left alone.
            if (in_list[c.node])
            begin
                n = {1'b0, c.node};
                p = prv_tbl[c.node];
                q = nxt_tbl[c.node];
                if (n == head_idx)
                    head_idx = q;
                if (n == tail_idx)
                    tail_idx = p;
                if (p != NO_LINK)
                    nxt_tbl[p[7:0]] = q;
                if (q != NO_LINK)
                    prv_tbl[q[7:0]] = p;
                prv_tbl[c.node] = NO_LINK;
                nxt_tbl[c.node] = free_idx;
                free_idx        = n;
                in_list[c.node] = 1'b0;
                node_count--;
            end
        end
        else
        begin
            // A read shows the raw memories, member or not.
            r.result_node = c.node;
            r.node_value  = payload_mem[c.node];
            r.next_none   = nxt_tbl[c.node][8];
            r.next_node   = r.next_none ? '0 : nxt_tbl[c.node][7:0];
            r.prev_none   = prv_tbl[c.node][8];
            r.prev_node   = r.prev_none ? '0 : prv_tbl[c.node][7:0];
        end
        r.head_none   = head_idx[8];
        r.head_node   = head_idx[8] ? '0 : head_idx[7:0];
        r.list_length = node_count;
        r.full_res    = (free_idx == NO_LINK) && (cap_used != 0);
    endtask

    // Pick a random set bit of a node mask, or -1 if none is set.
    function automatic int pick_from(input logic [POOL-1:0] mask);
        int total;
        int k;
        int i;
        total = $countones(mask);
        if (total == 0)
            return -1;
        k = $urandom_range(0, total - 1);
        for (i = 0; i < POOL; i++)
        begin
            if (mask[i])
            begin
                if (k == 0)
                    return i;
                k--;
            end
        end
        return -1;
    endfunction

    // Build a random command item, mostly well formed against the current list.
    task automatic gen_item(output cmd_t c, input bit grow);
        int w;
        int m;
        c.value      = {$urandom, $urandom};
        c.node       = NODE_W'($urandom);
        c.left_node  = NODE_W'($urandom);
        c.left_none  = 1'($urandom);
        c.right_node = NODE_W'($urandom);
        c.right_none = 1'($urandom);
        case ($urandom_range(0, 15))
            0: c.value = '0;
            1: c.value = '1;
            default: ;
        endcase
        w = $urandom_range(0, 99);
        if (grow)
            c.op = (w < 45) ? OP_APPEND : (w < 90) ? OP_INSERT : (w < 95) ? OP_REMOVE : OP_READ;
        else
            c.op = (w < 30) ? OP_APPEND : (w < 60) ? OP_INSERT : (w < 85) ? OP_REMOVE : OP_READ;

        if (c.op == OP_INSERT)
        begin
            w = $urandom_range(0, 99);
            if (w < 85)
            begin
                // Between a member and its successor, or in front of the head.
                m = pick_from(in_list);
                if (m < 0 || $urandom_range(0, 7) == 0)
                begin
                    c.left_none  = 1'b1;
                    c.right_none = head_idx[8];
                    if (!head_idx[8])
                        c.right_node = head_idx[7:0];
                end
                else
                begin
                    c.left_none  = 1'b0;
                    c.left_node  = m[7:0];
                    c.right_none = nxt_tbl[m][8];
                    if (!c.right_none)
                        c.right_node = nxt_tbl[m][7:0];
                end
            end
            else if (w < 97)
            begin
                // Members that need not be neighbors.
                m = pick_from(in_list);
                if (m >= 0)
                    c.left_node = m[7:0];
                m = pick_from(in_list);
                if (m >= 0)
                    c.right_node = m[7:0];
            end
        end
        else if (c.op == OP_REMOVE)
        begin
            m = pick_from(in_list);
            if (m >= 0 && $urandom_range(0, 9) != 0)
                c.node = m[7:0];
        end
        else if (c.op == OP_READ)
        begin
            // Only nodes whose payload has been stored are read.
            m = ($urandom_range(0, 4) != 0) ? pick_from(in_list) : -1;
            if (m < 0)
                m = pick_from(ever_written);
            if (m < 0)
                c.op = OP_APPEND;
            else
                c.node = m[7:0];
        end
    endtask

    // Drive one command item after a gap, wait for it to be taken, and predict it.
    task automatic issue(input cmd_t c, input int gap, input bit typed, input res_t typed_res);
        res_t r;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        op         = c.op;
        value      = c.value;
        node       = c.node;
        left_node  = c.left_node;
        left_none  = c.left_none;
        right_node = c.right_node;
        right_none = c.right_none;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        apply_list_op(c, r);
        if (typed)
        begin
            r.status      = typed_res.status;
            r.result_node = typed_res.result_node;
            r.list_length = typed_res.list_length;
            r.full_res    = typed_res.full_res;
        end
        pending_results.push_back(r);
    endtask

    // Write the capacity once the core has gone quiet.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        capacity_we   = 1'b1;
        capacity_data = cap;
        @(posedge clk);
        rebuild_pool(cap);
        @(negedge clk);
        capacity_we = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // Compare every result item with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        res_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result item with no command outstanding, node %0h",
                         $time, result_node);
                fail_cnt++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", 64'(e.status), 64'(status));
                check_field("result_node", 64'(e.result_node), 64'(result_node));
                check_field("node_value", e.node_value, node_value);
                check_field("next_node", 64'(e.next_node), 64'(next_node));
                check_field("next_none", 64'(e.next_none), 64'(next_none));
                check_field("prev_node", 64'(e.prev_node), 64'(prev_node));
                check_field("prev_none", 64'(e.prev_none), 64'(prev_none));
                check_field("head_node", 64'(e.head_node), 64'(head_node));
                check_field("head_none", 64'(e.head_none), 64'(head_none));
                check_field("list_length", 64'(e.list_length), 64'(list_length));
                check_field("full_res", 64'(e.full_res), 64'(full_res));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL pooled_doubly_linked_list_core");
            $finish;
        end
    end

    initial
    begin
        cmd_t c;
        res_t blank;
        res_t typed_res;
        int   cap;
        int   plen;
        int   phase;
        int   sent;
        bit   grow;
        bit   calm;

        blank         = '{default: '0};
        rst_n         = 1'b0;
        start         = 1'b0;
        op            = OP_APPEND;
        value         = '0;
        node          = '0;
        left_node     = '0;
        left_none     = 1'b0;
        right_node    = '0;
        right_none    = 1'b0;
        capacity_we   = 1'b0;
        capacity_data = '0;
        rebuild_pool(CAP_RESET);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                write_capacity(dir_tab[i].cap);
            end
            else
            begin
                c.op                  = dir_tab[i].op;
                c.value               = dir_tab[i].value;
                c.node                = dir_tab[i].node;
                c.left_node           = dir_tab[i].left_node;
                c.left_none           = dir_tab[i].left_none;
                c.right_node          = dir_tab[i].right_node;
                c.right_none          = dir_tab[i].right_none;
                typed_res             = blank;
                typed_res.status      = dir_tab[i].t_status;
                typed_res.result_node = dir_tab[i].t_node;
                typed_res.list_length = dir_tab[i].t_len;
                typed_res.full_res    = dir_tab[i].t_full;
                issue(c, $urandom_range(0, 9), dir_tab[i].typed, typed_res);
            end
        end

        // Random phases; the first one uses the whole pool and mostly grows the list.
        phase = 0;
        sent  = 0;
        while (sent < RAND_ITEMS)
        begin
            if (phase == 0)
            begin
                cap  = POOL;
                grow = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: cap = $urandom_range(1, 12);
                    5, 6:          cap = POOL;
                    7:             cap = $urandom_range(13, 255);
                    8:             cap = $urandom_range(257, 511);
                    default:       cap = 0;
                endcase
                grow = ($urandom_range(0, 3) == 0);
            end
            write_capacity(CAP_W'(cap));
            plen = (cap == 0) ? 15 : (grow && cap > 100) ? 300 : $urandom_range(60, 160);
            if (plen > RAND_ITEMS - sent)
                plen = RAND_ITEMS - sent;
            calm = ($urandom_range(0, 3) == 0);
            repeat (plen)
            begin
                gen_item(c, grow);
                issue(c, calm ? 0 : $urandom_range(0, 9), 1'b0, blank);
                sent++;
            end
            phase++;
        end

        // Let the last results arrive, then look for stray ones.
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (fail_cnt == 0)
            $display("PASS pooled_doubly_linked_list_core");
        else
            $display("FAIL pooled_doubly_linked_list_core");
        $finish;
    end

endmodule

// ===== pooled_doubly_linked_list_core.f =====
rtl/pdll_pkg.sv
rtl/pooled_doubly_linked_list_core.sv
tb/tb.sv
